FILE: src/fstc_pkg.sv
// fstc_pkg: shared types, constants and the circular run check for the
// segment-test corner detector; no dependencies
`default_nettype none

package fstc_pkg;

    // pixel and line store geometry
    localparam int PIXEL_BITS    = 8;
    localparam int NUM_LINES     = 6;
    localparam int WIN           = 7;
    localparam int LINE_W        = NUM_LINES * PIXEL_BITS;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int SUM_W         = PIXEL_BITS + 1;

    // register field widths
    localparam int THR_W  = 8;
    localparam int ARC_W  = 5;
    localparam int FW_W   = 11;
    localparam int FH_W   = 12;
    localparam int CFG_W  = 12;
    localparam int CIDX_W = 2;
    localparam int CMP_W  = 13;
    localparam int OCOL_W = 10;
    localparam int RING_N = 16;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ARC_LENGTH   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 2'd3;

    // register reset values
    localparam logic [THR_W-1:0] THR_RST = 8'd20;
    localparam logic [ARC_W-1:0] ARC_RST = 5'd9;
    localparam logic [FW_W-1:0]  FW_RST  = 11'd640;
    localparam logic [FH_W-1:0]  FH_RST  = 12'd480;
    localparam logic [FH_W-1:0]  ROW_MAX = 12'd4095;

    // radius-3 ring, offsets from the centre, clockwise from the top
    localparam int RING_DX [RING_N] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
    localparam int RING_DY [RING_N] = '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  frame_start;
    } pixel_word_t;

    typedef struct packed {
        logic              verdict_valid;
        logic              is_corner;
        logic [OCOL_W-1:0] cand_column;
        logic [FH_W-1:0]   cand_row;
    } result_word_t;

    // true when the 16-bit ring mask holds a circular run of at least len ones
    function automatic logic has_run(input logic [RING_N-1:0] mask,
                                     input logic [ARC_W-1:0] len);
        logic [2*RING_N-1:0] dbl;
        logic [RING_N-1:0]   len_mask;
        logic                hit;
        dbl = {mask, mask};
        if (len >= ARC_W'(RING_N))
            len_mask = '1;
        else
            len_mask = (RING_N'(1) << len) - RING_N'(1);
        hit = 1'b0;
        for (int i = 0; i < RING_N; i++)
        begin
            if (&(dbl[i +: RING_N] | ~len_mask))
                hit = 1'b1;
        end
        if (len > ARC_W'(RING_N))
            hit = 1'b0;
        return hit;
    endfunction

endpackage

`default_nettype wire

FILE: src/fast_segment_corner_test_core.sv
// fast_segment_corner_test_core: segment-test corner detector on a raster pixel stream
// throughput: one pixel per cycle unless result_stall backs up, limited by the
// single-port-per-side line memory; each pixel goes stage 1, stage 2, result register
// reset: counters clear, registers take their defaults, pipeline empties; the line
// memory is not swept, its old contents only reach candidates the border rule rejects
// depends on fstc_pkg
`default_nettype none

module fast_segment_corner_test_core
    import fstc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pixel_valid,
    output logic                   pixel_stall,
    input  wire pixel_word_t       pixel_word,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output result_word_t           result_word,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    // configuration registers
    logic [THR_W-1:0] thr_reg;
    logic [ARC_W-1:0] arc_reg;
    logic [FW_W-1:0]  fw_reg;
    logic [FH_W-1:0]  fh_reg;

    // position counters
    logic [CW-1:0]   col_reg, col_next;
    logic [FH_W-1:0] row_reg, row_next;

    // stage 1: pixel with its position, line word read back
    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_px_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [FH_W-1:0]       s1_row_reg;
    logic [LINE_W-1:0]     rd_word_reg;
    logic [LINE_W-1:0]     fwd_word_reg;
    logic                  fwd_reg;
    logic [LINE_W-1:0]     line_mem_reg [MAX_WIDTH];

    // stage 2: window and candidate info
    logic                  s2_valid_reg;
    logic [PIXEL_BITS-1:0] win_reg [WIN][WIN];
    logic                  s2_vv_reg;
    logic                  s2_interior_reg;
    logic [OCOL_W-1:0]     s2_col_reg;
    logic [FH_W-1:0]       s2_row_reg;

    // result register
    logic         out_valid_reg;
    result_word_t out_reg;

    // handshake chain
    logic out_free, s2_free, s1_free, s2_adv, s1_adv, in_fire;

    assign out_free    = !out_valid_reg || !result_stall;
    assign s2_adv      = s2_valid_reg && out_free;
    assign s2_free     = !s2_valid_reg || out_free;
    assign s1_adv      = s1_valid_reg && s2_free;
    assign s1_free     = !s1_valid_reg || s2_free;
    assign in_fire     = pixel_valid && s1_free;
    assign pixel_stall = !s1_free;
    assign cfg_ready   = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RST;
            arc_reg <= ARC_RST;
            fw_reg  <= FW_RST;
            fh_reg  <= FH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_THRESHOLD:    thr_reg <= cfg_data[THR_W-1:0];
                CFG_ARC_LENGTH:   arc_reg <= cfg_data[ARC_W-1:0];
                CFG_FRAME_WIDTH:  fw_reg  <= cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: fh_reg  <= cfg_data[FH_W-1:0];
                default:          thr_reg <= thr_reg;
            endcase
        end
    end

    // effective width and counter advance
    logic [CMP_W-1:0] w_eff, col_inc, row_inc;
    logic [CW-1:0]    col_cur;
    logic [FH_W-1:0]  row_cur;

    always_comb
    begin
        w_eff   = (CMP_W'(fw_reg) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : CMP_W'(fw_reg);
        col_cur = pixel_word.frame_start ? '0 : col_reg;
        row_cur = pixel_word.frame_start ? '0 : row_reg;
        col_inc = CMP_W'(col_cur) + CMP_W'(1);
        row_inc = CMP_W'(row_cur) + CMP_W'(1);
        col_next = col_inc[CW-1:0];
        row_next = row_cur;
        if (col_inc >= w_eff || col_inc >= CMP_W'(MAX_WIDTH))
        begin
            col_next = '0;
            if (row_inc >= CMP_W'(fh_reg) || row_cur >= ROW_MAX)
                row_next = '0;
            else
                row_next = row_inc[FH_W-1:0];
        end
    end

    // counters and stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    // column word as seen by stage 1, and its shifted write-back
    logic [LINE_W-1:0] col_word, wr_word;

    assign col_word = fwd_reg ? fwd_word_reg : rd_word_reg;
    assign wr_word  = {s1_px_reg, col_word[LINE_W-1:PIXEL_BITS]};

    // stage 1 payload and line memory; same-column hazard forwarded
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg    <= pixel_word.pixel;
            s1_col_reg   <= col_cur;
            s1_row_reg   <= row_cur;
            rd_word_reg  <= line_mem_reg[col_cur];
            fwd_reg      <= s1_adv && (s1_col_reg == col_cur);
            fwd_word_reg <= wr_word;
        end
        if (s1_adv)
            line_mem_reg[s1_col_reg] <= wr_word;
    end

    // candidate position and border test
    logic [CMP_W-1:0] c_ext;
    logic [CMP_W-1:0] cc_full;
    logic [FH_W-1:0]  cr_full;
    logic             vv, interior;

    always_comb
    begin
        c_ext    = CMP_W'(s1_col_reg);
        cc_full  = c_ext - CMP_W'(3);
        cr_full  = s1_row_reg - FH_W'(3);
        vv       = (c_ext >= CMP_W'(3)) && (s1_row_reg >= FH_W'(3));
        interior = (c_ext >= CMP_W'(6)) && (c_ext < w_eff)
                   && (s1_row_reg >= FH_W'(6)) && (s1_row_reg < fh_reg);
    end

    // stage 2 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_adv)
            s2_valid_reg <= 1'b1;
        else if (s2_adv)
            s2_valid_reg <= 1'b0;
    end

    // window shift and candidate info
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            for (int y = 0; y < WIN; y++)
            begin
                for (int x = 0; x < WIN - 1; x++)
                    win_reg[y][x] <= win_reg[y][x+1];
            end
            for (int y = 0; y < NUM_LINES; y++)
                win_reg[y][WIN-1] <= col_word[y*PIXEL_BITS +: PIXEL_BITS];
            win_reg[WIN-1][WIN-1] <= s1_px_reg;
            s2_vv_reg       <= vv;
            s2_interior_reg <= interior;
            s2_col_reg      <= vv ? cc_full[OCOL_W-1:0] : '0;
            s2_row_reg      <= vv ? cr_full : '0;
        end
    end

    // ring compares against centre
    logic [RING_N-1:0]     bright, dark;
    logic [PIXEL_BITS-1:0] centre;
    logic [SUM_W-1:0]      centre_hi;
    logic                  seg_hit;

    always_comb
    begin
        centre    = win_reg[3][3];
        centre_hi = SUM_W'(centre) + SUM_W'(thr_reg);
        for (int i = 0; i < RING_N; i++)
        begin
            bright[i] = SUM_W'(win_reg[3+RING_DY[i]][3+RING_DX[i]]) > centre_hi;
            dark[i]   = (SUM_W'(win_reg[3+RING_DY[i]][3+RING_DX[i]]) + SUM_W'(thr_reg))
                        < SUM_W'(centre);
        end
        seg_hit = has_run(bright, arc_reg) || has_run(dark, arc_reg);
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_adv)
            out_valid_reg <= 1'b1;
        else if (out_free)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_reg.verdict_valid <= s2_vv_reg;
            out_reg.is_corner     <= s2_vv_reg && s2_interior_reg && seg_hit;
            out_reg.cand_column   <= s2_col_reg;
            out_reg.cand_row      <= s2_row_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_reg;

`ifndef SYNTH
    // input only backs up when every stage is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg))
        else $error("pixel stall with a free stage");

    // column counter stays inside the line memory
    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(col_reg) < CMP_W'(MAX_WIDTH))
        else $error("column counter beyond line memory");

    // a word leaving stage 1 always lands in stage 2
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> s2_valid_reg)
        else $error("stage 2 lost a word");

    // no candidate means an all-zero verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_word.verdict_valid) |->
        (!result_word.is_corner && result_word.cand_column == '0
         && result_word.cand_row == '0))
        else $error("verdict fields set without a candidate");

    // corners never lie on the top or left frame border
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_word.is_corner) |->
        (result_word.cand_column >= OCOL_W'(3) && result_word.cand_row >= FH_W'(3)))
        else $error("corner reported on the border");
`endif

endmodule

`default_nettype wire
